// ===== hdl/fts_pkg.sv =====
// shared types, constants and helpers for the file type sniffer
package fts_pkg;

  localparam int HeaderBytes = 12;
  localparam int HtmlSearchSpan = 256;
  localparam int OffsetCap = HtmlSearchSpan + 3;
  localparam int PosW = $clog2(HeaderBytes + 1);
  localparam int OffW = $clog2(OffsetCap + 1);
  localparam int QDepth = 3;

  localparam logic [4:0] FT_UNKNOWN = 5'd0;
  localparam logic [4:0] FT_PNG = 5'd1;
  localparam logic [4:0] FT_JPG = 5'd2;
  localparam logic [4:0] FT_GIF = 5'd3;
  localparam logic [4:0] FT_BMP = 5'd4;
  localparam logic [4:0] FT_ICO = 5'd5;
  localparam logic [4:0] FT_WEBP = 5'd6;
  localparam logic [4:0] FT_TIFF = 5'd7;
  localparam logic [4:0] FT_WAV = 5'd8;
  localparam logic [4:0] FT_AVI = 5'd9;
  localparam logic [4:0] FT_MP4 = 5'd10;
  localparam logic [4:0] FT_MKV = 5'd11;
  localparam logic [4:0] FT_MP3 = 5'd12;
  localparam logic [4:0] FT_OGG = 5'd13;
  localparam logic [4:0] FT_FLAC = 5'd14;
  localparam logic [4:0] FT_PDF = 5'd15;
  localparam logic [4:0] FT_ZIP = 5'd16;
  localparam logic [4:0] FT_RAR = 5'd17;
  localparam logic [4:0] FT_7Z = 5'd18;
  localparam logic [4:0] FT_GZIP = 5'd19;
  localparam logic [4:0] FT_JSON = 5'd20;
  localparam logic [4:0] FT_HTML = 5'd21;
  localparam logic [4:0] FT_XML = 5'd22;
  localparam logic [4:0] FT_TXT = 5'd23;
  localparam logic [4:0] FT_BIN = 5'd24;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [4:0] file_type;
    logic       utf8_valid;
  } out_item_t;

  // end-of-window summary handed from the scanner to the classifier
  typedef struct packed {
    logic [HeaderBytes-1:0][7:0] hdr;
    logic [PosW-1:0]             n;
    logic                        valid;
    logic                        text_found;
    logic [7:0]                  text_char;
    logic                        html;
  } summary_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ===== hdl/fts_scan.sv =====
// front part: per-byte header capture, utf-8 check and text tracking
module fts_scan (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_go,
  input  fts_pkg::in_item_t  item,
  output logic               sum_go,
  output fts_pkg::summary_t  sum
);

  logic [fts_pkg::HeaderBytes-1:0][7:0] hdr;
  logic [fts_pkg::PosW-1:0] pos;
  logic [1:0]  u_rem, u_len;
  logic [20:0] u_cp;
  logic        u_fail;
  logic        t_found;
  logic [7:0]  t_char;
  logic [fts_pkg::OffW-1:0] off;
  logic        doc_ok, html_seen;
  logic [23:0] recent;

  logic [fts_pkg::HeaderBytes-1:0][7:0] hdr_next;
  logic [fts_pkg::PosW-1:0] pos_next;
  logic [1:0]  u_rem_next, u_len_next;
  logic [20:0] u_cp_next;
  logic        u_fail_next, t_found_next, doc_ok_next, html_seen_next;
  logic [7:0]  t_char_next;
  logic [fts_pkg::OffW-1:0] off_next;
  logic [23:0] recent_next;

  logic [7:0] b, lb;
  logic [7:0] doc_ch;
  logic       sp;

  always_comb begin
    b = item.data_byte;
    lb = fts_pkg::to_lower(b);
    sp = (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) || (b == 8'h0A) ||
         (b == 8'h0C) || (b == 8'h0B);
    hdr_next = hdr;
    pos_next = pos;
    u_rem_next = u_rem;
    u_len_next = u_len;
    u_cp_next = u_cp;
    u_fail_next = u_fail;
    t_found_next = t_found;
    t_char_next = t_char;
    off_next = off;
    doc_ok_next = doc_ok;
    html_seen_next = html_seen;
    recent_next = recent;
    doc_ch = 8'h00;
    if (item.has_byte) begin
      if (pos < fts_pkg::PosW'(fts_pkg::HeaderBytes)) begin
        hdr_next[pos[$clog2(fts_pkg::HeaderBytes)-1:0]] = b;
        pos_next = pos + 1'b1;
      end
      // utf-8 check
      if (!u_fail) begin
        if (u_rem == 2'd0) begin
          if (b == 8'h00) u_fail_next = 1'b1;
          else if (b < 8'h80) begin
          end else if ((b & 8'hE0) == 8'hC0) begin
            u_len_next = 2'd1; u_rem_next = 2'd1; u_cp_next = {16'd0, b[4:0]};
          end else if ((b & 8'hF0) == 8'hE0) begin
            u_len_next = 2'd2; u_rem_next = 2'd2; u_cp_next = {17'd0, b[3:0]};
          end else if ((b & 8'hF8) == 8'hF0) begin
            u_len_next = 2'd3; u_rem_next = 2'd3; u_cp_next = {18'd0, b[2:0]};
          end else u_fail_next = 1'b1;
        end else if (b[7:6] != 2'b10) begin
          u_fail_next = 1'b1;
        end else begin
          u_cp_next = {u_cp[14:0], b[5:0]};
          u_rem_next = u_rem - 2'd1;
          if (u_rem == 2'd1) begin
            case (u_len)
              2'd1: if (u_cp_next < 21'h80) u_fail_next = 1'b1;
              2'd2: if (u_cp_next < 21'h800 ||
                        (u_cp_next >= 21'hD800 && u_cp_next <= 21'hDFFF))
                      u_fail_next = 1'b1;
              default: if (u_cp_next < 21'h10000 || u_cp_next > 21'h10FFFF)
                         u_fail_next = 1'b1;
            endcase
          end
        end
      end
      // text tracking
      if (!t_found) begin
        if (!sp) begin
          t_found_next = 1'b1;
          t_char_next = b;
          off_next = '0;
          doc_ok_next = (b == "<");
          html_seen_next = 1'b0;
        end
      end else begin
        if (off < fts_pkg::OffW'(fts_pkg::OffsetCap)) off_next = off + 1'b1;
        if (t_char == "<") begin
          case (off_next)
            fts_pkg::OffW'(1): doc_ch = "!";
            fts_pkg::OffW'(2): doc_ch = "d";
            fts_pkg::OffW'(3): doc_ch = "o";
            fts_pkg::OffW'(4): doc_ch = "c";
            fts_pkg::OffW'(5): doc_ch = "t";
            fts_pkg::OffW'(6): doc_ch = "y";
            fts_pkg::OffW'(7): doc_ch = "p";
            fts_pkg::OffW'(8): doc_ch = "e";
            default: doc_ch = 8'h00;
          endcase
          if (off_next >= fts_pkg::OffW'(1) && off_next <= fts_pkg::OffW'(8) &&
              lb != doc_ch)
            doc_ok_next = 1'b0;
          if (lb == "l" && off_next >= fts_pkg::OffW'(3) &&
              off_next < fts_pkg::OffW'(fts_pkg::HtmlSearchSpan + 3) &&
              fts_pkg::to_lower(recent[23:16]) == "h" &&
              fts_pkg::to_lower(recent[15:8]) == "t" &&
              fts_pkg::to_lower(recent[7:0]) == "m")
            html_seen_next = 1'b1;
        end
      end
      recent_next = {recent[15:0], b};
      // byte order mark restarts the text tracker
      if (pos == fts_pkg::PosW'(2) && hdr[0] == 8'hEF && hdr[1] == 8'hBB && b == 8'hBF) begin
        t_found_next = 1'b0;
        t_char_next = 8'h00;
        off_next = '0;
        doc_ok_next = 1'b0;
        html_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      u_rem <= '0; u_len <= '0; u_cp <= '0; u_fail <= 1'b0;
      t_found <= 1'b0; t_char <= '0; off <= '0;
      doc_ok <= 1'b0; html_seen <= 1'b0; recent <= '0;
      sum_go <= 1'b0;
    end else begin
      sum_go <= in_go && item.last;
      if (in_go) begin
        if (item.last) begin
          pos <= '0;
          u_rem <= '0; u_len <= '0; u_cp <= '0; u_fail <= 1'b0;
          t_found <= 1'b0; t_char <= '0; off <= '0;
          doc_ok <= 1'b0; html_seen <= 1'b0; recent <= '0;
        end else begin
          pos <= pos_next;
          u_rem <= u_rem_next; u_len <= u_len_next; u_cp <= u_cp_next;
          u_fail <= u_fail_next;
          t_found <= t_found_next; t_char <= t_char_next; off <= off_next;
          doc_ok <= doc_ok_next; html_seen <= html_seen_next;
          recent <= recent_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) hdr <= item.last ? hdr_next : hdr_next;
    if (in_go && item.last) begin
      sum.hdr <= hdr_next;
      sum.n <= pos_next;
      sum.valid <= !u_fail_next && u_rem_next == 2'd0;
      sum.text_found <= t_found_next;
      sum.text_char <= t_char_next;
      sum.html <= doc_ok_next && html_seen_next;
    end
  end

endmodule

// ===== hdl/fts_queue.sv =====
// short queue of window summaries between scanner and classifier
module fts_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  fts_pkg::summary_t wdata,
  input  logic              rd,
  output logic              has_data,
  output logic [1:0]        level,
  output fts_pkg::summary_t rdata
);

  fts_pkg::summary_t mem [fts_pkg::QDepth];
  logic [1:0] wp, rp;

  assign has_data = level != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 2'd0; rp <= 2'd0; level <= 2'd0;
    end else begin
      if (wr) wp <= (wp == 2'(fts_pkg::QDepth - 1)) ? 2'd0 : wp + 2'd1;
      if (rd) rp <= (rp == 2'(fts_pkg::QDepth - 1)) ? 2'd0 : rp + 2'd1;
      level <= level + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule

// ===== hdl/fts_classify.sv =====
// back part: signature match and final type decision into an output register
module fts_classify (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_has,
  input  fts_pkg::summary_t s,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output fts_pkg::out_item_t result
);

  logic [4:0] ft;
  logic [7:0] h [fts_pkg::HeaderBytes];
  logic [4:0] n;
  logic       riff;

  always_comb begin
    for (int i = 0; i < fts_pkg::HeaderBytes; i++) h[i] = s.hdr[i];
    n = 5'(s.n);
    riff = n >= 5'd12 && h[0] == "R" && h[1] == "I" && h[2] == "F" && h[3] == "F";
    if (n == 5'd0) ft = fts_pkg::FT_UNKNOWN;
    else if (n >= 5'd8 && h[0] == 8'h89 && h[1] == "P" && h[2] == "N" && h[3] == "G" &&
             h[4] == 8'h0D && h[5] == 8'h0A && h[6] == 8'h1A && h[7] == 8'h0A)
      ft = fts_pkg::FT_PNG;
    else if (n >= 5'd2 && h[0] == 8'hFF && h[1] == 8'hD8) ft = fts_pkg::FT_JPG;
    else if (n >= 5'd6 && h[0] == "G" && h[1] == "I" && h[2] == "F" && h[3] == "8" &&
             (h[4] == "7" || h[4] == "9") && h[5] == "a")
      ft = fts_pkg::FT_GIF;
    else if (n >= 5'd2 && h[0] == "B" && h[1] == "M") ft = fts_pkg::FT_BMP;
    else if (n >= 5'd4 && h[0] == 8'h00 && h[1] == 8'h00 && h[2] == 8'h01 && h[3] == 8'h00)
      ft = fts_pkg::FT_ICO;
    else if (riff && h[8] == "W" && h[9] == "E" && h[10] == "B" && h[11] == "P")
      ft = fts_pkg::FT_WEBP;
    else if (n >= 5'd4 && ((h[0] == "I" && h[1] == "I" && h[2] == 8'h2A && h[3] == 8'h00) ||
             (h[0] == "M" && h[1] == "M" && h[2] == 8'h00 && h[3] == 8'h2A)))
      ft = fts_pkg::FT_TIFF;
    else if (riff && h[8] == "W" && h[9] == "A" && h[10] == "V" && h[11] == "E")
      ft = fts_pkg::FT_WAV;
    else if (riff && h[8] == "A" && h[9] == "V" && h[10] == "I" && h[11] == " ")
      ft = fts_pkg::FT_AVI;
    else if (n >= 5'd12 && h[4] == "f" && h[5] == "t" && h[6] == "y" && h[7] == "p")
      ft = fts_pkg::FT_MP4;
    else if (n >= 5'd4 && h[0] == 8'h1A && h[1] == 8'h45 && h[2] == 8'hDF && h[3] == 8'hA3)
      ft = fts_pkg::FT_MKV;
    else if ((n >= 5'd3 && h[0] == "I" && h[1] == "D" && h[2] == "3") ||
             (n >= 5'd2 && h[0] == 8'hFF && h[1][7:5] == 3'b111))
      ft = fts_pkg::FT_MP3;
    else if (n >= 5'd4 && h[0] == "O" && h[1] == "g" && h[2] == "g" && h[3] == "S")
      ft = fts_pkg::FT_OGG;
    else if (n >= 5'd4 && h[0] == "f" && h[1] == "L" && h[2] == "a" && h[3] == "C")
      ft = fts_pkg::FT_FLAC;
    else if (n >= 5'd5 && h[0] == "%" && h[1] == "P" && h[2] == "D" && h[3] == "F" &&
             h[4] == "-")
      ft = fts_pkg::FT_PDF;
    else if (n >= 5'd4 && h[0] == "P" && h[1] == "K" &&
             (h[2] == 8'd3 || h[2] == 8'd5 || h[2] == 8'd7) &&
             (h[3] == 8'd4 || h[3] == 8'd6 || h[3] == 8'd8))
      ft = fts_pkg::FT_ZIP;
    else if (n >= 5'd7 && h[0] == "R" && h[1] == "a" && h[2] == "r" && h[3] == "!" &&
             h[4] == 8'h1A && h[5] == 8'h07 &&
             (h[6] == 8'h00 || (n >= 5'd8 && h[6] == 8'h01 && h[7] == 8'h00)))
      ft = fts_pkg::FT_RAR;
    else if (n >= 5'd6 && h[0] == "7" && h[1] == "z" && h[2] == 8'hBC && h[3] == 8'hAF &&
             h[4] == 8'h27 && h[5] == 8'h1C)
      ft = fts_pkg::FT_7Z;
    else if (n >= 5'd2 && h[0] == 8'h1F && h[1] == 8'h8B) ft = fts_pkg::FT_GZIP;
    else if (s.text_found && s.valid && (s.text_char == "{" || s.text_char == "["))
      ft = fts_pkg::FT_JSON;
    else if (s.text_found && s.valid && s.text_char == "<")
      ft = s.html ? fts_pkg::FT_HTML : fts_pkg::FT_XML;
    else ft = s.valid ? fts_pkg::FT_TXT : fts_pkg::FT_BIN;
  end

  // output register refills as soon as it is free or being popped
  assign q_rd = q_has && (empty || pop);

  always_ff @(posedge clk) begin
    if (rst) empty <= 1'b1;
    else if (q_rd) empty <= 1'b0;
    else if (pop) empty <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result.file_type <= ft;
      result.utf8_valid <= s.valid;
    end
  end

endmodule

// ===== hdl/file_type_sniff.sv =====
// top level of the file type sniffer
// Accepts one byte per cycle while full is low, with no gaps required; a window
// closes on the item with last set and its single result passes through the
// scanner register, the queue and the classifier output register to the result
// port. Up to three finished results buffer between the stages plus one in the
// output register; full rises only when results go unread and the queue,
// counting a summary still in the scanner register, has no room left.
module file_type_sniff (
  input  logic               clk,
  input  logic               rst,
  input  fts_pkg::in_item_t  in_item,
  input  logic               push,
  output logic               full,
  output fts_pkg::out_item_t out_item,
  output logic               empty,
  input  logic               pop
);

  logic              go, sum_go, q_has, q_rd;
  logic [1:0]        level;
  fts_pkg::summary_t sum, qs;

  // room must cover a summary already in flight from the scanner
  assign full = ({1'b0, level} + {2'b00, sum_go}) >= 3'(fts_pkg::QDepth);
  assign go = push && !full;

  fts_scan u_scan (.clk, .rst, .in_go(go), .item(in_item), .sum_go, .sum);

  fts_queue u_queue (.clk, .rst, .wr(sum_go), .wdata(sum), .rd(q_rd),
                     .has_data(q_has), .level, .rdata(qs));

  fts_classify u_cls (.clk, .rst, .q_has, .s(qs), .q_rd, .empty, .pop,
                      .result(out_item));

endmodule

// ===== hdl/fts_checker.sv =====
// port-level checks for the file type sniffer, bound to the top level
module fts_assertions (
  input logic               clk,
  input logic               rst,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input fts_pkg::out_item_t out_item
);

  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.file_type <= fts_pkg::FT_BIN)
    else $error("file type out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("result changed while waiting");

  a_text_valid: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.file_type >= fts_pkg::FT_JSON &&
    out_item.file_type <= fts_pkg::FT_TXT |-> out_item.utf8_valid)
    else $error("text type without valid utf-8");

  a_bin: assert property (@(posedge clk) disable iff (rst)
    !empty && out_item.file_type == fts_pkg::FT_BIN |-> !out_item.utf8_valid)
    else $error("binary type with valid utf-8");

  a_reset: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("not idle after reset");

endmodule

bind file_type_sniff fts_assertions u_fts_assertions (.clk, .rst, .full, .pop, .empty,
                                                      .out_item);

// ===== sim/fts_checker.sv =====
// checker for the file type sniffer: predicts window results and compares them
module fts_checker (
  input  logic               clk,
  input  logic               rst,
  input  fts_pkg::in_item_t  in_item,
  input  logic               push,
  input  logic               full,
  input  fts_pkg::out_item_t out_item,
  input  logic               empty,
  input  logic               pop,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0] hdr [fts_pkg::HeaderBytes];
  int unsigned nbytes, u_rem, u_len, u_cp, offs;
  bit u_bad, txt_found, doc_ok, html_hit;
  logic [7:0] txt_char;
  logic [23:0] last3;
  fts_pkg::out_item_t verdicts[$];

  function automatic logic [7:0] lc(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0C || c == 8'h0B;
  endfunction

  function automatic bit hdr_is(int p, logic [7:0] s[], int unsigned n);
    if (p + s.size() > n) return 0;
    foreach (s[k]) if (hdr[p+k] !== s[k]) return 0;
    return 1;
  endfunction

  task automatic clear_window();
    nbytes = 0; u_rem = 0; u_len = 0; u_cp = 0; u_bad = 0; txt_found = 0;
    txt_char = 0; offs = 0; doc_ok = 0; html_hit = 0; last3 = 0;
  endtask

  task automatic utf8_step(logic [7:0] b);
    if (u_bad) return;
    if (u_rem == 0) begin
      if (b == 0) u_bad = 1;
      else if (b < 8'h80) ;
      else if ((b & 8'hE0) == 8'hC0) begin u_len = 1; u_rem = 1; u_cp = b & 8'h1F; end
      else if ((b & 8'hF0) == 8'hE0) begin u_len = 2; u_rem = 2; u_cp = b & 8'h0F; end
      else if ((b & 8'hF8) == 8'hF0) begin u_len = 3; u_rem = 3; u_cp = b & 8'h07; end
      else u_bad = 1;
      return;
    end
    if ((b & 8'hC0) != 8'h80) begin
      u_bad = 1;
      return;
    end
    u_cp = ((u_cp << 6) | (b & 8'h3F)) & 32'h1FFFFF;
    u_rem--;
    if (u_rem != 0) return;
    if (u_len == 1) u_bad = u_cp < 32'h80;
    else if (u_len == 2) u_bad = u_cp < 32'h800 || (u_cp >= 32'hD800 && u_cp <= 32'hDFFF);
    else u_bad = u_cp < 32'h10000 || u_cp > 32'h10FFFF;
  endtask

  task automatic text_step(int unsigned p, logic [7:0] b);
    logic [7:0] dword[8];
    logic [7:0] l;
    dword = '{"!", "d", "o", "c", "t", "y", "p", "e"};
    if (!txt_found) begin
      if (!is_ws(b)) begin
        txt_found = 1; txt_char = b; offs = 0; doc_ok = (b == "<"); html_hit = 0;
      end
    end else begin
      if (offs < fts_pkg::OffsetCap) offs++;
      if (txt_char == "<") begin
        l = lc(b);
        if (offs >= 1 && offs <= 8 && l != dword[offs-1]) doc_ok = 0;
        if (l == "l" && offs >= 3 && offs - 3 < fts_pkg::HtmlSearchSpan &&
            lc(last3[23:16]) == "h" && lc(last3[15:8]) == "t" && lc(last3[7:0]) == "m")
          html_hit = 1;
      end
    end
    last3 = {last3[15:0], b};
    if (p == 2 && hdr[0] == 8'hEF && hdr[1] == 8'hBB && hdr[2] == 8'hBF) begin
      txt_found = 0; txt_char = 0; offs = 0; doc_ok = 0; html_hit = 0;
    end
  endtask

  function automatic logic [4:0] classify(bit ok);
    int unsigned n;
    n = nbytes;
    if (n == 0) return fts_pkg::FT_UNKNOWN;
    if (hdr_is(0, '{8'h89, "P", "N", "G", 8'h0D, 8'h0A, 8'h1A, 8'h0A}, n))
      return fts_pkg::FT_PNG;
    if (hdr_is(0, '{8'hFF, 8'hD8}, n)) return fts_pkg::FT_JPG;
    if (hdr_is(0, '{"G", "I", "F", "8", "7", "a"}, n) ||
        hdr_is(0, '{"G", "I", "F", "8", "9", "a"}, n)) return fts_pkg::FT_GIF;
    if (hdr_is(0, '{"B", "M"}, n)) return fts_pkg::FT_BMP;
    if (hdr_is(0, '{8'h00, 8'h00, 8'h01, 8'h00}, n)) return fts_pkg::FT_ICO;
    if (n >= 12 && hdr_is(0, '{"R", "I", "F", "F"}, n)) begin
      if (hdr_is(8, '{"W", "E", "B", "P"}, n)) return fts_pkg::FT_WEBP;
    end
    if (hdr_is(0, '{"I", "I", 8'h2A, 8'h00}, n) ||
        hdr_is(0, '{"M", "M", 8'h00, 8'h2A}, n)) return fts_pkg::FT_TIFF;
    if (n >= 12 && hdr_is(0, '{"R", "I", "F", "F"}, n)) begin
      if (hdr_is(8, '{"W", "A", "V", "E"}, n)) return fts_pkg::FT_WAV;
      if (hdr_is(8, '{"A", "V", "I", " "}, n)) return fts_pkg::FT_AVI;
    end
    if (n >= 12 && hdr_is(4, '{"f", "t", "y", "p"}, n)) return fts_pkg::FT_MP4;
    if (hdr_is(0, '{8'h1A, 8'h45, 8'hDF, 8'hA3}, n)) return fts_pkg::FT_MKV;
    if (hdr_is(0, '{"I", "D", "3"}, n) || (n >= 2 && hdr[0] == 8'hFF && hdr[1][7:5] == 3'b111))
      return fts_pkg::FT_MP3;
    if (hdr_is(0, '{"O", "g", "g", "S"}, n)) return fts_pkg::FT_OGG;
    if (hdr_is(0, '{"f", "L", "a", "C"}, n)) return fts_pkg::FT_FLAC;
    if (hdr_is(0, '{"%", "P", "D", "F", "-"}, n)) return fts_pkg::FT_PDF;
    if (n >= 4 && hdr[0] == "P" && hdr[1] == "K" && hdr[2] inside {3, 5, 7} &&
        hdr[3] inside {4, 6, 8}) return fts_pkg::FT_ZIP;
    if (hdr_is(0, '{"R", "a", "r", "!", 8'h1A, 8'h07, 8'h00}, n) ||
        hdr_is(0, '{"R", "a", "r", "!", 8'h1A, 8'h07, 8'h01, 8'h00}, n))
      return fts_pkg::FT_RAR;
    if (hdr_is(0, '{"7", "z", 8'hBC, 8'hAF, 8'h27, 8'h1C}, n)) return fts_pkg::FT_7Z;
    if (hdr_is(0, '{8'h1F, 8'h8B}, n)) return fts_pkg::FT_GZIP;
    if (txt_found && ok) begin
      if (txt_char == "{" || txt_char == "[") return fts_pkg::FT_JSON;
      if (txt_char == "<") return (doc_ok && html_hit) ? fts_pkg::FT_HTML : fts_pkg::FT_XML;
    end
    return ok ? fts_pkg::FT_TXT : fts_pkg::FT_BIN;
  endfunction

  always @(posedge clk) begin
    fts_pkg::out_item_t want;
    bit ok;
    int unsigned p;
    if (rst) begin
      clear_window();
      verdicts.delete();
      fail_count <= 0;
    end else begin
      if (push && !full) begin
        if (in_item.has_byte) begin
          p = nbytes;
          if (nbytes < fts_pkg::HeaderBytes) begin
            hdr[nbytes] = in_item.data_byte;
            nbytes++;
          end
          utf8_step(in_item.data_byte);
          text_step(p, in_item.data_byte);
        end
        if (in_item.last) begin
          ok = !u_bad && u_rem == 0;
          want.file_type = classify(ok);
          want.utf8_valid = ok;
          verdicts.push_back(want);
          clear_window();
        end
      end
      if (pop && !empty) begin
        if (verdicts.size() == 0) begin
          if (fail_count < 10) $display("unexpected transaction: type %0d valid %0b",
                                        out_item.file_type, out_item.utf8_valid);
          fail_count <= fail_count + 1;
        end else begin
          want = verdicts.pop_front();
          if (out_item !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected type %0d valid %0b, got type %0d valid %0b",
                       want.file_type, want.utf8_valid, out_item.file_type,
                       out_item.utf8_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = verdicts.size();
  end
endmodule

// ===== sim/tb_top.sv =====
// top of the file type sniffer testbench: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1, push = 0, pop = 0, full, empty;
  fts_pkg::in_item_t in_item = '0;
  fts_pkg::out_item_t out_item;
  int fail_count, pending, push_idle, pop_idle;
  int sent;

  file_type_sniff uut (.clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
                       .out_item(out_item), .empty(empty), .pop(pop));

  fts_checker chk (.clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
                   .out_item(out_item), .empty(empty), .pop(pop), .fail_count(fail_count),
                   .pending(pending));

  always #10 clk = ~clk;

  // one transaction: hold push until accepted, with random gaps first
  task automatic send(logic [7:0] b, bit has, bit fin);
    while ($urandom_range(99) < push_idle) begin
      push <= 0;
      @(negedge clk);
    end
    in_item <= '{data_byte: b, has_byte: has, last: fin};
    push <= 1;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_window(logic [7:0] w[$]);
    foreach (w[k]) send(w[k], 1, k == w.size() - 1);
  endtask

  function automatic logic [7:0] rand_ascii();
    return 8'($urandom_range(32, 126));
  endfunction

  // well-formed and broken windows of many kinds
  task automatic random_window();
    logic [7:0] w[$];
    int kind, len, cp;
    logic [31:0] tag;
    logic [63:0] tag8;
    string dt_up, dt_lo;
    kind = $urandom_range(11);
    len = $urandom_range(0, 14);
    dt_up = "!DOCTYPE";
    dt_lo = "!doctype";
    case (kind)
      0: repeat (len + 1) w.push_back(8'($urandom_range(255)));
      1: begin
        w = '{8'h89, "P", "N", "G", 8'h0D, 8'h0A, 8'h1A, 8'h0A, "R", "I", "F", "F"};
        w[$urandom_range(11)] = 8'($urandom_range(255));
        w = w[0:$urandom_range(11)];
      end
      2: begin
        w = '{"R", "I", "F", "F", 1, 2, 3, 4, "W", "A", "V", "E", 0};
        if ($urandom_range(1)) begin
          tag = "WEBP";
          for (int k = 0; k < 4; k++) w[8+k] = tag[31-8*k -: 8];
        end
        if ($urandom_range(1)) begin
          tag = "AVI ";
          for (int k = 0; k < 4; k++) w[8+k] = tag[31-8*k -: 8];
        end
        if ($urandom_range(2) == 0) begin
          tag8 = {8'h00, 8'h00, 8'h00, 8'h08, "ftyp"};
          for (int k = 0; k < 8; k++) w[k] = tag8[63-8*k -: 8];
        end
        w = w[0:$urandom_range(8, 12)];
      end
      3: begin
        case ($urandom_range(9))
          0: w = '{8'hFF, 8'hD8};  1: w = '{"G", "I", "F", "8", "9", "a"};
          2: w = '{"B", "M"};      3: w = '{0, 0, 1, 0};
          4: w = '{"I", "I", 8'h2A, 0}; 5: w = '{"M", "M", 0, 8'h2A};
          6: w = '{8'h1A, 8'h45, 8'hDF, 8'hA3}; 7: w = '{"I", "D", "3"};
          8: w = '{"P", "K", 3, 4};
          default: w = '{"R", "a", "r", "!", 8'h1A, 8'h07, 1, 0};
        endcase
        if ($urandom_range(3) == 0) void'(w.pop_back());
        repeat ($urandom_range(3)) w.push_back(8'($urandom_range(255)));
      end
      4: begin
        case ($urandom_range(6))
          0: w = '{"O", "g", "g", "S"};  1: w = '{"f", "L", "a", "C"};
          2: w = '{"%", "P", "D", "F", "-"}; 3: w = '{"7", "z", 8'hBC, 8'hAF, 8'h27, 8'h1C};
          4: w = '{8'h1F, 8'h8B}; 5: w = '{"R", "a", "r", "!", 8'h1A, 8'h07, 0};
          default: w = '{8'hFF, 8'hE0 | 8'($urandom_range(31))};
        endcase
        if ($urandom_range(3) == 0) void'(w.pop_back());
      end
      5, 6: begin
        if ($urandom_range(2) == 0) w = '{8'hEF, 8'hBB, 8'hBF};
        repeat ($urandom_range(3)) w.push_back($urandom_range(1) ? " " : 8'h0A);
        w.push_back("<");
        if ($urandom_range(3)) begin
          for (int k = 0; k < 8; k++) w.push_back($urandom_range(1) ? dt_up[k] : dt_lo[k]);
          if ($urandom_range(4) == 0) w[$ - $urandom_range(7)] = "x";
        end
        repeat ($urandom_range(20)) w.push_back(rand_ascii());
        if ($urandom_range(3)) begin
          w.push_back($urandom_range(1) ? "h" : "H"); w.push_back("t");
          w.push_back($urandom_range(1) ? "m" : "M"); w.push_back("l");
        end
        if ($urandom_range(5) == 0) repeat (260) w.push_back(" ");
        if ($urandom_range(5) == 0) w.push_back(8'h00);
      end
      7: begin
        repeat ($urandom_range(3)) w.push_back(8'h09);
        w.push_back($urandom_range(1) ? "{" : "[");
        repeat (len) w.push_back(rand_ascii());
      end
      default: begin
        // utf-8 text with occasional bad sequences
        repeat (len + 1) begin
          case ($urandom_range(4))
            0: w.push_back(rand_ascii());
            1: begin cp = $urandom_range(0, 12'h7FF);
              w.push_back(8'hC0 | cp[10:6]); w.push_back(8'h80 | cp[5:0]); end
            2: begin cp = $urandom_range(0, 16'hFFFF);
              w.push_back(8'hE0 | cp[15:12]); w.push_back(8'h80 | cp[11:6]);
              w.push_back(8'h80 | cp[5:0]); end
            3: begin cp = $urandom_range(0, 21'h1FFFFF);
              w.push_back(8'hF0 | cp[20:18]); w.push_back(8'h80 | cp[17:12]);
              w.push_back(8'h80 | cp[11:6]); w.push_back(8'h80 | cp[5:0]); end
            default: w.push_back(8'($urandom_range(255)));
          endcase
        end
        if ($urandom_range(4) == 0) void'(w.pop_back());
      end
    endcase
    if (w.size() == 0) begin
      send(8'($urandom_range(255)), 0, 1);
      return;
    end
    foreach (w[k]) begin
      if ($urandom_range(15) == 0) send(8'($urandom_range(255)), 0, 0);
      if (k == w.size() - 1 && $urandom_range(5) == 0) begin
        send(w[k], 1, 0);
        send(8'($urandom_range(255)), 0, 1);
      end else send(w[k], 1, k == w.size() - 1);
    end
  endtask

  always @(negedge clk) begin
    if (rst) pop <= 0;
    else pop <= $urandom_range(99) >= pop_idle;
  end

  initial begin
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int guard;
    push_idle = 11;
    pop_idle = 84;
    sent = 0;
    repeat (2) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed windows
    send(8'h00, 0, 1);
    send(8'hFF, 0, 0);
    send(8'h41, 1, 0);
    send(8'h00, 0, 1);
    send_window('{8'h89, "P", "N", "G", 8'h0D, 8'h0A, 8'h1A});
    send_window('{8'hEF, 8'hBB, 8'hBF, "{", "}"});
    send_window('{"<", "!", "D", "O", "C", "T", "Y", "P", "E", " ", "h", "t", "m", "l"});
    send_window('{"<", "x", "m", "l"});
    send_window('{8'hC0, 8'h80});
    send_window('{8'hED, 8'hA0, 8'h80});
    send_window('{8'hF4, 8'h90, 8'h80, 8'h80});
    send_window('{"a", 8'hE2, 8'h82});
    send_window('{"a", 8'h00});
    send_window('{8'hFF});
    while (sent < 1750) begin
      if (sent > 600 && push_idle == 11) begin
        push_idle = 84;
        pop_idle = 11;
      end else if (sent > 1200 && push_idle == 84) begin
        push_idle = 0;
        pop_idle = 0;
      end
      random_window();
    end
    push <= 0;
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (20) @(negedge clk);
    if (guard < 100000 && fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
